[rtl/core/sks_pkg.sv]
// shared types and constants for the sorted key set
package sks_pkg;

   localparam int CapacityDefault = 64;
   localparam int KeyWidth        = 32;
   localparam int PosWidth        = 6;
   localparam int CountOutWidth   = 7;

   typedef enum logic [1:0] {
      FUNC_ADD    = 2'd0,
      FUNC_REMOVE = 2'd1,
      FUNC_EXIST  = 2'd2,
      FUNC_READ   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE    = 2'd0,
      ST_COMPARE = 2'd1,
      ST_UPDATE  = 2'd2,
      ST_RESP    = 2'd3
   } state_type;

   typedef struct packed {
      logic load;
      logic compare;
      logic update;
   } cmd_type;

endpackage

[rtl/core/sks_if.sv]
// request and response channel interfaces
interface sks_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    func;
   logic [sks_pkg::KeyWidth-1:0]  key;
   logic [sks_pkg::PosWidth-1:0]  position;

   modport source (output valid, func, key, position, input ready);
   modport sink   (input valid, func, key, position, output ready);
endinterface

interface sks_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        status;
   logic                              present;
   logic [sks_pkg::KeyWidth-1:0]      value;
   logic [sks_pkg::CountOutWidth-1:0] entry_count;

   modport source (output valid, status, present, value, entry_count, input ready);
   modport sink   (input valid, status, present, value, entry_count, output ready);
endinterface

[rtl/core/sorted_key_set_top.sv]
// Sorted set of distinct 32-bit keys held in a chain of CAPACITY cells in
// ascending order. Each item adds, removes, tests or reads at a position and
// gives one response with the count after the item. An item goes through
// accept, all-cell compare, shift and update, and response, in that order;
// the response is valid after the compare and update states that follow accept.
// Only one item is in the block at a time, and the next item is taken the
// cycle after the response is consumed. An add of a key not in the set to a
// full set reports full and leaves the set unchanged.
module sorted_key_set_top #(
   parameter int CAPACITY = sks_pkg::CapacityDefault
) (
   input logic       clock,
   input logic       reset,
   sks_req_if.sink   req,
   sks_rsp_if.source rsp
);

   sks_pkg::cmd_type              cmd;
   logic [$clog2(CAPACITY+1)-1:0] count;

   sks_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd)
   );

   sks_dp #(.CAPACITY(CAPACITY)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_func        (req.func),
      .req_key         (req.key),
      .req_position    (req.position),
      .rsp_status      (rsp.status),
      .rsp_present     (rsp.present),
      .rsp_value       (rsp.value),
      .rsp_entry_count (rsp.entry_count),
      .count           (count)
   );

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count <= ($clog2(CAPACITY+1))'(CAPACITY))
      else $error("count above capacity");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready && !rsp.valid)
      else $error("item accepted while busy");

   a_back_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.ready) |=> req.ready && !rsp.valid)
      else $error("no return to idle after response");

   a_count_steady: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |=> $stable(count) || $past(rsp.ready))
      else $error("count moved while response pending");

endmodule

[rtl/core/sks_ctrl.sv]
// sequencer for compare, update and response phases
module sks_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sks_pkg::cmd_type cmd
);

   sks_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sks_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sks_pkg::ST_IDLE: begin
            if (req_valid) state_in = sks_pkg::ST_COMPARE;
         end
         sks_pkg::ST_COMPARE: begin
            state_in = sks_pkg::ST_UPDATE;
         end
         sks_pkg::ST_UPDATE: begin
            state_in = sks_pkg::ST_RESP;
         end
         sks_pkg::ST_RESP: begin
            if (rsp_ready) state_in = sks_pkg::ST_IDLE;
         end
         default: begin
            state_in = sks_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready   = (state_ff == sks_pkg::ST_IDLE);
      rsp_valid   = (state_ff == sks_pkg::ST_RESP);
      cmd.load    = (state_ff == sks_pkg::ST_IDLE) && req_valid;
      cmd.compare = (state_ff == sks_pkg::ST_COMPARE);
      cmd.update  = (state_ff == sks_pkg::ST_UPDATE);
   end

endmodule

[rtl/core/sks_dp.sv]
// chain of key cells with per-cell compare and shift
module sks_dp #(
   parameter int CAPACITY = sks_pkg::CapacityDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   input  sks_pkg::cmd_type                  cmd,
   input  logic [1:0]                        req_func,
   input  logic [sks_pkg::KeyWidth-1:0]      req_key,
   input  logic [sks_pkg::PosWidth-1:0]      req_position,
   output logic [1:0]                        rsp_status,
   output logic                              rsp_present,
   output logic [sks_pkg::KeyWidth-1:0]      rsp_value,
   output logic [sks_pkg::CountOutWidth-1:0] rsp_entry_count,
   output logic [$clog2(CAPACITY+1)-1:0]     count
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (sks_pkg::PosWidth > CW) ? sks_pkg::PosWidth : CW;

   logic [sks_pkg::KeyWidth-1:0] cell_ff [CAPACITY];
   logic [sks_pkg::KeyWidth-1:0] cell_in [CAPACITY];
   logic [CAPACITY-1:0]          valid;
   logic [CAPACITY-1:0]          lt_ff;
   logic [CAPACITY-1:0]          eq_ff;
   logic [CAPACITY-1:0]          sel;
   logic [CW-1:0]                count_ff, count_in;
   logic [1:0]                   func_ff;
   logic [sks_pkg::KeyWidth-1:0] key_ff;
   logic [sks_pkg::PosWidth-1:0] pos_ff;
   logic                         hit;
   logic                         full;
   logic                         do_add, do_remove;
   logic [sks_pkg::KeyWidth-1:0] read_val;
   logic [1:0]                   status_ff, status_in;
   logic                         present_ff;
   logic [sks_pkg::KeyWidth-1:0] value_ff, value_in;

   assign hit       = |(eq_ff & valid);
   assign full      = (count_ff == CW'(CAPACITY));
   assign do_add    = (func_ff == sks_pkg::FUNC_ADD) && !hit && !full;
   assign do_remove = (func_ff == sks_pkg::FUNC_REMOVE) && hit;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign valid[i] = CW'(i) < count_ff;
      assign sel[i]   = valid[i] && (PW'(pos_ff) == PW'(i));

      always_comb begin
         cell_in[i] = cell_ff[i];
         if (do_add && !lt_ff[i]) begin
            if (i == 0) begin
               cell_in[i] = key_ff;
            end else if (lt_ff[(i == 0) ? 0 : i-1]) begin
               cell_in[i] = key_ff;
            end else begin
               cell_in[i] = cell_ff[(i == 0) ? 0 : i-1];
            end
         end else if (do_remove && !lt_ff[i] && (i < CAPACITY-1)) begin
            cell_in[i] = cell_ff[(i < CAPACITY-1) ? i+1 : i];
         end
      end

      always_ff @(posedge clock) begin
         if (cmd.compare) begin
            lt_ff[i] <= valid[i] && (cell_ff[i] < key_ff);
            eq_ff[i] <= (cell_ff[i] == key_ff);
         end
         if (cmd.update) cell_ff[i] <= cell_in[i];
      end
   end

   // one cell at most is selected, so an or-reduction is the read mux
   always_comb begin
      read_val = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         read_val = read_val | (sel[i] ? cell_ff[i] : '0);
      end
   end

   always_comb begin
      count_in  = count_ff;
      status_in = sks_pkg::STATUS_OK;
      value_in  = '0;
      if (do_add) count_in = count_ff + CW'(1);
      if (do_remove) count_in = count_ff - CW'(1);
      if ((func_ff == sks_pkg::FUNC_ADD) && !hit && full) status_in = sks_pkg::STATUS_FULL;
      if ((func_ff == sks_pkg::FUNC_REMOVE) && !hit) status_in = sks_pkg::STATUS_NOT_FOUND;
      if (func_ff == sks_pkg::FUNC_READ) value_in = read_val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.update) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_func;
         key_ff  <= req_key;
         pos_ff  <= req_position;
      end
      if (cmd.update) begin
         status_ff  <= status_in;
         present_ff <= hit;
         value_ff   <= value_in;
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_present     = present_ff;
   assign rsp_value       = value_ff;
   assign rsp_entry_count = sks_pkg::CountOutWidth'(count_ff);
   assign count           = count_ff;

endmodule
